>>> hdl/assert_macros.svh
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked every cycle out of reset
`define MEXP_ASSERT(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define MEXP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define MEXP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> hdl/mexp_pkg.sv
// shared constants and types for the modular exponentiation core
package mexp_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int CNT_W      = $clog2(DATA_WIDTH);
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 1'd1;

	typedef struct packed {
		logic                  start;
		logic                  reduce;
		logic [DATA_WIDTH-1:0] a;
		logic [DATA_WIDTH-1:0] b;
	} mm_req_t;

endpackage

>>> hdl/mexp_mulmod.sv
// bit-serial modular multiply and reduce unit, one operand bit per cycle
`include "assert_macros.svh"

module mexp_mulmod (
	input  logic                             clk,
	input  logic                             arst_n,
	input  mexp_pkg::mm_req_t                req,
	input  logic [mexp_pkg::DATA_WIDTH-1:0]  m,
	output logic                             done,
	output logic [mexp_pkg::DATA_WIDTH-1:0]  product
);

	logic [mexp_pkg::DATA_WIDTH-1:0] acc_q;
	logic [mexp_pkg::DATA_WIDTH-1:0] a_q;
	logic [mexp_pkg::DATA_WIDTH-1:0] b_q;
	logic                            reduce_q;
	logic [mexp_pkg::CNT_W-1:0]      cnt_q;
	logic                            busy_q;
	logic                            done_q;

	logic                            bit_cur;
	logic [mexp_pkg::DATA_WIDTH:0]   m_ext;
	logic [mexp_pkg::DATA_WIDTH:0]   dbl;
	logic [mexp_pkg::DATA_WIDTH-1:0] red1;
	logic [mexp_pkg::DATA_WIDTH:0]   sum;
	logic [mexp_pkg::DATA_WIDTH-1:0] red2;
	logic [mexp_pkg::DATA_WIDTH-1:0] acc_nxt;

	always_comb begin
		bit_cur = b_q[cnt_q];
		m_ext   = {1'b0, m};
		// double, shifting in the dividend bit when reducing
		dbl     = {acc_q, (reduce_q & bit_cur)};
		red1    = (dbl >= m_ext) ? mexp_pkg::DATA_WIDTH'(dbl - m_ext)
			: dbl[mexp_pkg::DATA_WIDTH-1:0];
		sum     = {1'b0, red1} + {1'b0, a_q};
		red2    = (sum >= m_ext) ? mexp_pkg::DATA_WIDTH'(sum - m_ext)
			: sum[mexp_pkg::DATA_WIDTH-1:0];
		acc_nxt = (!reduce_q && bit_cur) ? red2 : red1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= mexp_pkg::CNT_W'(mexp_pkg::DATA_WIDTH - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q    <= '0;
			a_q      <= req.a;
			b_q      <= req.b;
			reduce_q <= req.reduce;
		end else if (busy_q) begin
			acc_q <= acc_nxt;
		end
	end

	assign done    = done_q;
	assign product = acc_q;

	`MEXP_ASSERT_IMP(a_done_not_busy, done_q, !busy_q)
	`MEXP_ASSERT_NXT(a_start_runs, req.start, busy_q && !done_q)

endmodule

>>> hdl/modular_exponentiation_core.sv
// modular exponentiation core: message ^ exponent mod modulus
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+---------------------------
//  input    | in        | in_valid / in_stall   | message
//  output   | out       | out_valid / out_stall | result
//  config   | in        | cfg_we                | cfg_index, cfg_data
//
// one beat runs one reduction pass, then per exponent bit a square and, for a
// set bit, a multiply, each on the single bit-serial multiply unit
// a zero modulus skips the multiply unit and puts 0 in the output register via S_DONE
// reset sets exponent and modulus to 1 and empties the output register
// a finished result waits in the output register while the next beat is taken
`include "assert_macros.svh"

module modular_exponentiation_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [mexp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mexp_pkg::DATA_WIDTH-1:0]      cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [mexp_pkg::DATA_WIDTH-1:0]      message,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [mexp_pkg::DATA_WIDTH-1:0]      result
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RED,
		S_SQR,
		S_MUL,
		S_DONE
	} state_t;

	state_t                          state_q;
	logic [mexp_pkg::DATA_WIDTH-1:0] exponent_q;
	logic [mexp_pkg::DATA_WIDTH-1:0] modulus_q;
	logic [mexp_pkg::DATA_WIDTH-1:0] base_q;
	logic [mexp_pkg::DATA_WIDTH-1:0] acc_q;
	logic [mexp_pkg::DATA_WIDTH-1:0] result_q;
	logic [mexp_pkg::CNT_W-1:0]      idx_q;
	logic                            out_valid_q;
	mexp_pkg::mm_req_t               req_q;

	logic                            mm_done;
	logic [mexp_pkg::DATA_WIDTH-1:0] mm_product;
	logic [mexp_pkg::DATA_WIDTH-1:0] one_mod;
	logic                            in_take;

	assign one_mod  = (modulus_q == mexp_pkg::DATA_WIDTH'(1)) ? '0
		: mexp_pkg::DATA_WIDTH'(1);
	assign in_stall = (state_q != S_IDLE);
	assign in_take  = in_valid && !in_stall;

	mexp_mulmod u_mulmod (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_q),
		.m       (modulus_q),
		.done    (mm_done),
		.product (mm_product)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exponent_q <= mexp_pkg::DATA_WIDTH'(1);
			modulus_q  <= mexp_pkg::DATA_WIDTH'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				mexp_pkg::REG_EXPONENT: exponent_q <= cfg_data;
				mexp_pkg::REG_MODULUS:  modulus_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			out_valid_q  <= 1'b0;
			req_q.start  <= 1'b0;
			req_q.reduce <= 1'b0;
			idx_q        <= '0;
		end else begin
			req_q.start <= 1'b0;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						if (modulus_q == '0) begin
							acc_q   <= '0;
							state_q <= S_DONE;
						end else begin
							req_q.start  <= 1'b1;
							req_q.reduce <= 1'b1;
							req_q.b      <= message;
							req_q.a      <= '0;
							state_q      <= S_RED;
						end
					end
				end
				S_RED: begin
					if (mm_done) begin
						base_q       <= mm_product;
						idx_q        <= mexp_pkg::CNT_W'(mexp_pkg::DATA_WIDTH - 1);
						req_q.start  <= 1'b1;
						req_q.reduce <= 1'b0;
						req_q.a      <= one_mod;
						req_q.b      <= one_mod;
						state_q      <= S_SQR;
					end
				end
				S_SQR: begin
					if (mm_done) begin
						acc_q <= mm_product;
						if (exponent_q[idx_q]) begin
							req_q.start <= 1'b1;
							req_q.a     <= mm_product;
							req_q.b     <= base_q;
							state_q     <= S_MUL;
						end else if (idx_q == '0) begin
							state_q <= S_DONE;
						end else begin
							idx_q       <= idx_q - 1'b1;
							req_q.start <= 1'b1;
							req_q.a     <= mm_product;
							req_q.b     <= mm_product;
						end
					end
				end
				S_MUL: begin
					if (mm_done) begin
						acc_q <= mm_product;
						if (idx_q == '0) begin
							state_q <= S_DONE;
						end else begin
							idx_q       <= idx_q - 1'b1;
							req_q.start <= 1'b1;
							req_q.a     <= mm_product;
							req_q.b     <= mm_product;
							state_q     <= S_SQR;
						end
					end
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						result_q    <= acc_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;

	`MEXP_ASSERT_IMP(a_done_while_waiting, mm_done,
		state_q == S_RED || state_q == S_SQR || state_q == S_MUL)
	`MEXP_ASSERT_NXT(a_take_leaves_idle, in_take, state_q != S_IDLE)
	`MEXP_ASSERT_IMP(a_start_only_busy, req_q.start, state_q != S_IDLE && state_q != S_DONE)

endmodule
